[rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// ile_pkg
// Shared codes and types for the indexed list engine: request codes,
// status codes and the per-cell shift command.
// ----------------------------------------------------------------------------
package ile_pkg;

  // request codes
  localparam logic [2:0] F_PUSH     = 3'd0;
  localparam logic [2:0] F_POP      = 3'd1;
  localparam logic [2:0] F_INSERT   = 3'd2;
  localparam logic [2:0] F_REMOVE   = 3'd3;
  localparam logic [2:0] F_GET      = 3'd4;
  localparam logic [2:0] F_PUT      = 3'd5;
  localparam logic [2:0] F_SEARCH   = 3'd6;
  localparam logic [2:0] F_SRCH_DEL = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CK_HOLD,    // keep contents
    CK_INSERT,  // cell p takes the word, cells above p up to n take left neighbor
    CK_DELETE,  // cells p .. n-2 take right neighbor
    CK_FILL     // cells n .. p-1 clear, cell p takes the word
  } cell_kind_t;

endpackage

[rtl/ile_if.sv]
// ----------------------------------------------------------------------------
// ile_if
// Valid/ready channels of the indexed list engine: request and response.
// ----------------------------------------------------------------------------
interface ile_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [5:0]  index;
  logic [31:0] value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface ile_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] data_out;
  logic [5:0]  position;
  logic [6:0]  count;

  modport source (output valid, output status, output data_out, output position,
                  output count, input ready);
  modport sink   (input valid, input status, input data_out, input position,
                  input count, output ready);
endinterface

[rtl/indexed_list_engine_unit.sv]
// Push/pop/insert/remove/get/put run in S_EXEC, which waits for a free response
// slot; the cell chain updates in one step. Requests are taken only in S_IDLE.
// Search scans groups of 8 cells up to the first hit or the last live group
//   (at most ceil(CAPACITY/8) groups); search-and-remove adds the S_TAKE state.
// Reset clears the count and control only; cell words stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Ordered word list of up to CAPACITY entries held in a chain of cells with a
// broadcast command, registered match flags and an 8-bit-per-cycle first-hit scan.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_req_if.sink   in_req,
  ile_rsp_if.source out_rsp
);
  import ile_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;
  localparam int AW   = $clog2(CAPACITY);
  localparam int NG   = (CAPACITY + 7) / 8;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW   = GW + 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_TAKE = 2'd3;

  localparam logic [CMPW-1:0] CAP_X = CMPW'(CAPACITY);

  function automatic logic [2:0] first_set8(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (b[k]) r = 3'(k);
    end
    return r;
  endfunction

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [2:0]           func_r;
  logic [5:0]           idx_r;
  logic [WORD_BITS-1:0] w_r;
  logic [NG*8-1:0]      hit_r;
  logic [GW-1:0]        grp_r, grp_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [31:0]          out_data_r;
  logic [5:0]           out_pos_r;
  logic [6:0]           out_count_r;

  logic [WORD_BITS-1:0] cell_q [CAPACITY];
  logic [CAPACITY-1:0]  hit_vec;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_word;

  cell_kind_t           kind_raw, kind;
  logic [CMPW-1:0]      cp, cn;
  logic [CW-1:0]        count_raw;
  logic                 finish, commit, slot_free, hit_cap;
  logic [1:0]           res_status;
  logic [31:0]          res_data;
  logic [5:0]           res_pos;
  logic [CMPW-1:0]      cnt_x, idx_x;
  logic [7:0]           grp_bits;
  logic [GW-1:0]        last_grp;
  logic                 scan_last;

  assign cnt_x     = CMPW'(count_r);
  assign idx_x     = CMPW'(idx_r);
  assign slot_free = !out_valid_r || out_rsp.ready;
  assign rd_word   = cell_q[rd_addr];
  assign grp_bits  = hit_r[{grp_r, 3'b000} +: 8];
  assign last_grp  = GW'((cnt_x - 1'b1) >> 3);
  assign scan_last = (count_r == '0) || (grp_r == last_grp);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_lo
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_hi
      assign right_w = cell_q[i+1];
    end
    ile_cell #(
      .WORD_BITS (WORD_BITS),
      .CMPW      (CMPW),
      .IDX       (i)
    ) u_cell (
      .clk     (clk),
      .kind    (kind),
      .p       (cp),
      .n       (cn),
      .wr_word (w_r),
      .left_q  (left_w),
      .right_q (right_w),
      .q       (cell_q[i]),
      .hit     (hit_vec[i])
    );
  end

  always_comb begin
    state_nxt  = state_r;
    kind_raw   = CK_HOLD;
    cp         = idx_x;
    cn         = cnt_x;
    count_raw  = count_r;
    rd_addr    = AW'(idx_r);
    finish     = 1'b0;
    hit_cap    = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_pos    = '0;
    grp_nxt    = grp_r;
    pos_nxt    = pos_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (func_r)
          F_PUSH: begin
            finish = 1'b1;
            if (cnt_x >= CAP_X) begin
              res_status = ST_FULL;
            end else begin
              kind_raw  = CK_FILL;
              cp        = cnt_x;
              count_raw = count_r + 1'b1;
            end
          end
          F_POP: begin
            finish = 1'b1;
            if (count_r == '0) begin
              res_status = ST_MISS;
            end else begin
              rd_addr   = AW'(cnt_x - 1'b1);
              res_data  = 32'(rd_word);
              count_raw = count_r - 1'b1;
            end
          end
          F_INSERT, F_PUT: begin
            finish = 1'b1;
            if (idx_x < cnt_x) begin
              if (func_r == F_PUT) begin
                // overwrite in place
                kind_raw = CK_FILL;
                cn       = idx_x;
              end else if (cnt_x >= CAP_X) begin
                res_status = ST_FULL;
              end else begin
                kind_raw  = CK_INSERT;
                count_raw = count_r + 1'b1;
              end
            end else if (idx_x >= CAP_X) begin
              res_status = ST_FULL;
            end else begin
              // past the end: zero the gap, then place the word
              kind_raw  = CK_FILL;
              count_raw = CW'(idx_x + 1'b1);
            end
          end
          F_REMOVE, F_GET: begin
            finish = 1'b1;
            if (idx_x >= cnt_x) begin
              res_status = ST_MISS;
            end else begin
              res_data = 32'(rd_word);
              if (func_r == F_REMOVE) begin
                kind_raw  = CK_DELETE;
                count_raw = count_r - 1'b1;
              end
            end
          end
          F_SEARCH, F_SRCH_DEL: begin
            hit_cap   = 1'b1;
            grp_nxt   = '0;
            state_nxt = S_SCAN;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (grp_bits != 8'd0) begin
          pos_nxt = {grp_r, first_set8(grp_bits)};
          if (func_r == F_SEARCH) begin
            finish  = 1'b1;
            res_pos = 6'(pos_nxt);
          end else begin
            state_nxt = S_TAKE;
          end
        end else if (scan_last) begin
          finish     = 1'b1;
          res_status = ST_MISS;
        end else begin
          grp_nxt = grp_r + 1'b1;
        end
      end
      S_TAKE: begin
        finish    = 1'b1;
        rd_addr   = AW'(pos_r);
        res_data  = 32'(rd_word);
        res_pos   = 6'(pos_r);
        kind_raw  = CK_DELETE;
        cp        = CMPW'(pos_r);
        count_raw = count_r - 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    commit    = finish && slot_free;
    kind      = commit ? kind_raw : CK_HOLD;
    count_nxt = commit ? count_raw : count_r;
    if (commit) state_nxt = S_IDLE;
  end

  assign in_req.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      grp_r       <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      grp_r   <= grp_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      func_r <= in_req.func;
      idx_r  <= in_req.index;
      w_r    <= WORD_BITS'(in_req.value);
    end
    if (hit_cap) begin
      hit_r <= (NG*8)'(hit_vec);
    end
    pos_r <= pos_nxt;
    if (commit) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_pos_r    <= res_pos;
      out_count_r  <= 7'(count_raw);
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.data_out = out_data_r;
  assign out_rsp.position = out_pos_r;
  assign out_rsp.count    = out_count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(CAPACITY) >= count_r)
    else $error("list count above capacity");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res_status == ST_FULL) |=> $stable(count_r))
    else $error("rejected request changed the count");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && state_r == S_EXEC && func_r == F_POP && res_status == ST_OK)
      |=> count_r == $past(count_r) - 1'b1)
    else $error("pop did not decrement the count");

  a_scan_only_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_TAKE) |-> func_r[2:1] == 2'b11)
    else $error("scan entered for a non-search request");

  a_no_commit_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |-> kind == CK_HOLD)
    else $error("cells updated while response slot is occupied");
`endif

endmodule

[rtl/ile_cell.sv]
// ----------------------------------------------------------------------------
// ile_cell
// One slot of the list. Holds a word, shifts it to/from its neighbors on
// insert/delete, and compares it against the broadcast word for search.
// ----------------------------------------------------------------------------
module ile_cell #(
  parameter int WORD_BITS = 32,
  parameter int CMPW      = 8,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  ile_pkg::cell_kind_t   kind,
  input  logic [CMPW-1:0]       p,
  input  logic [CMPW-1:0]       n,
  input  logic [WORD_BITS-1:0]  wr_word,
  input  logic [WORD_BITS-1:0]  left_q,
  input  logic [WORD_BITS-1:0]  right_q,
  output logic [WORD_BITS-1:0]  q,
  output logic                  hit
);
  import ile_pkg::*;

  localparam logic [CMPW-1:0] POS  = CMPW'(IDX);
  localparam logic [CMPW-1:0] POS1 = CMPW'(IDX + 1);

  logic [WORD_BITS-1:0] word_r, word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (kind)
      CK_HOLD: word_nxt = word_r;
      CK_INSERT: begin
        if (POS == p) begin
          word_nxt = wr_word;
        end else if (POS > p && POS <= n) begin
          word_nxt = left_q;
        end
      end
      CK_DELETE: begin
        if (POS >= p && POS1 < n) begin
          word_nxt = right_q;
        end
      end
      CK_FILL: begin
        if (POS == p) begin
          word_nxt = wr_word;
        end else if (POS >= n && POS < p) begin
          word_nxt = '0;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q   = word_r;
  // only live entries (below the count on n) can match
  assign hit = (word_r == wr_word) && (POS < n);

endmodule

[sim/ile_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// ile_scoreboard_pkg
// Scoreboard for the indexed list engine: keeps a shadow copy of the list,
// predicts the response of every accepted request and checks responses in order.
// ----------------------------------------------------------------------------
package ile_scoreboard_pkg;
  import ile_pkg::*;

  localparam int LIST_DEPTH = 64;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [5:0]  position;
    logic [6:0]  count;
  } list_rsp_t;

  class list_scoreboard;
    logic [31:0] cells [LIST_DEPTH];
    int unsigned fill;
    list_rsp_t   rsp_q[$];
    int          errors;
    int          checked;

    function new();
      fill    = 0;
      errors  = 0;
      checked = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Store w at at; past the end the gap is zero filled. Returns 0 when full.
    function bit place_word(input int unsigned at, input logic [31:0] w);
      if (at < fill) begin
        if (fill >= LIST_DEPTH) return 1'b0;
        for (int unsigned i = fill; i > at; i--) cells[i] = cells[i-1];
        cells[at] = w;
        fill++;
        return 1'b1;
      end
      if (at >= LIST_DEPTH) return 1'b0;
      for (int unsigned i = fill; i < at; i++) cells[i] = '0;
      cells[at] = w;
      fill = at + 1;
      return 1'b1;
    endfunction

    function logic [31:0] take_word(input int unsigned at);
      logic [31:0] w;
      w = cells[at];
      fill--;
      for (int unsigned i = at; i < fill; i++) cells[i] = cells[i+1];
      return w;
    endfunction

    function bit find_word(input logic [31:0] w, output int unsigned at);
      at = 0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (cells[i] == w) begin
          at = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(input logic [2:0] f, input logic [5:0] idx,
                               input logic [31:0] w);
      list_rsp_t   r;
      int unsigned p;
      r = '{ST_OK, 32'd0, 6'd0, 7'd0};
      case (f)
        F_PUSH:   if (!place_word(fill, w)) r.status = ST_FULL;
        F_POP: begin
          if (fill == 0) r.status = ST_MISS;
          else begin
            fill--;
            r.data_out = cells[fill];
          end
        end
        F_INSERT: if (!place_word(idx, w)) r.status = ST_FULL;
        F_REMOVE: begin
          if (idx >= fill) r.status = ST_MISS;
          else r.data_out = take_word(idx);
        end
        F_GET: begin
          if (idx >= fill) r.status = ST_MISS;
          else r.data_out = cells[idx];
        end
        F_PUT: begin
          if (idx < fill) cells[idx] = w;
          else if (!place_word(idx, w)) r.status = ST_FULL;
        end
        F_SEARCH: begin
          if (find_word(w, p)) r.position = p[5:0];
          else r.status = ST_MISS;
        end
        default: begin
          if (find_word(w, p)) begin
            r.position = p[5:0];
            r.data_out = take_word(p);
          end else begin
            r.status = ST_MISS;
          end
        end
      endcase
      r.count = fill[6:0];
      rsp_q.push_back(r);
    endfunction

    task check_response(input logic [1:0] status, input logic [31:0] data_out,
                        input logic [5:0] position, input logic [6:0] count);
      list_rsp_t e;
      if (rsp_q.size() == 0) begin
        report($sformatf("response with no request pending (status %0d)", status));
        return;
      end
      e = rsp_q.pop_front();
      if (status !== e.status)
        report($sformatf("rsp %0d status %0d, want %0d", checked, status, e.status));
      if (data_out !== e.data_out)
        report($sformatf("rsp %0d data_out %h, want %h", checked, data_out, e.data_out));
      if (position !== e.position)
        report($sformatf("rsp %0d position %0d, want %0d", checked, position, e.position));
      if (count !== e.count)
        report($sformatf("rsp %0d count %0d, want %0d", checked, count, e.count));
      checked++;
    endtask
  endclass

endpackage

[sim/indexed_list_engine_unit_tb.sv]
// ----------------------------------------------------------------------------
// indexed_list_engine_unit_tb
// Drives list requests (directed corner cases, then random traffic that walks
// the fill level between empty and full) under random source and sink stalls
// (not the last phase); checks responses with the scoreboard's shadow list.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ile_pkg::*;
  import ile_scoreboard_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_ITEMS  = 400;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [31:0] POOL [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                       32'h1234_5678, 32'h0000_00FF};

  logic clk = 1'b0;
  logic rst_n;

  ile_req_if req_ch ();
  ile_rsp_if rsp_ch ();

  indexed_list_engine_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  list_scoreboard sb = new();

  int src_idle_pct;
  int snk_stall_pct;
  int idle_cycles;
  bit growing;

  always #4 clk = ~clk;

  // response side: random backpressure, check every accepted response
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.status, rsp_ch.data_out, rsp_ch.position, rsp_ch.count);
      rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("indexed_list_engine_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] f, input logic [5:0] idx,
                              input logic [31:0] w);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    req_ch.valid <= 1'b1;
    req_ch.func  <= f;
    req_ch.index <= idx;
    req_ch.value <= w;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(f, idx, w);
  endtask

  // Random request biased to drift the fill level up, then back down.
  function automatic void pick_request(output logic [2:0] f, output logic [5:0] idx,
                                       output logic [31:0] w);
    int n;
    int r;
    n = sb.fill;
    if (n >= 60 && $urandom_range(0, 3) == 0) growing = 1'b0;
    if (n <= 3 && $urandom_range(0, 3) == 0) growing = 1'b1;
    r = $urandom_range(0, 99);
    if (growing) begin
      if      (r < 28) f = F_PUSH;
      else if (r < 46) f = F_INSERT;
      else if (r < 56) f = F_PUT;
      else if (r < 64) f = F_POP;
      else if (r < 72) f = F_REMOVE;
      else if (r < 82) f = F_GET;
      else if (r < 92) f = F_SEARCH;
      else             f = F_SRCH_DEL;
    end else begin
      if      (r < 8)  f = F_PUSH;
      else if (r < 14) f = F_INSERT;
      else if (r < 18) f = F_PUT;
      else if (r < 40) f = F_POP;
      else if (r < 60) f = F_REMOVE;
      else if (r < 72) f = F_GET;
      else if (r < 84) f = F_SEARCH;
      else             f = F_SRCH_DEL;
    end
    // mostly in range or just at the end; now and then anywhere
    if ($urandom_range(0, 9) == 0) idx = 6'($urandom_range(0, 63));
    else idx = 6'($urandom_range(0, (n > 63) ? 63 : n));
    if ((f == F_SEARCH || f == F_SRCH_DEL) && n > 0 && $urandom_range(0, 9) < 7)
      w = sb.cells[$urandom_range(0, n - 1)];
    else if ($urandom_range(0, 1) == 0)
      w = POOL[$urandom_range(0, 7)];
    else
      w = $urandom;
  endfunction

  initial begin
    logic [2:0]  f;
    logic [5:0]  idx;
    logic [31:0] w;

    req_ch.valid <= 1'b0;
    req_ch.func  <= F_PUSH;
    req_ch.index <= '0;
    req_ch.value <= '0;
    rst_n        <= 1'b0;
    growing      = 1'b1;
    src_idle_pct  = 12;
    snk_stall_pct = 78;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty list: every read-type request misses
    send_request(F_POP,      6'd0,  32'h0);
    send_request(F_REMOVE,   6'd0,  32'h0);
    send_request(F_GET,      6'd0,  32'h0);
    send_request(F_SEARCH,   6'd0,  32'h0);
    send_request(F_SRCH_DEL, 6'd0,  32'h5);
    send_request(F_PUSH,     6'd0,  32'hFFFF_FFFF);
    send_request(F_PUSH,     6'd63, 32'h0);
    send_request(F_INSERT,   6'd0,  32'hA5A5_A5A5);
    // insert past the end: gap gets zeros
    send_request(F_INSERT,   6'd5,  32'h1234_5678);
    send_request(F_GET,      6'd3,  32'h0);
    send_request(F_SEARCH,   6'd0,  32'h0);
    send_request(F_PUT,      6'd1,  32'h5A5A_5A5A);
    // put at the last slot fills the list completely
    send_request(F_PUT,      6'd63, 32'hDEAD_BEEF);
    send_request(F_PUSH,     6'd0,  32'h1);
    send_request(F_INSERT,   6'd0,  32'h2);
    send_request(F_INSERT,   6'd63, 32'h3);
    send_request(F_GET,      6'd63, 32'h0);
    send_request(F_SRCH_DEL, 6'd0,  32'h1234_5678);
    send_request(F_REMOVE,   6'd62, 32'h0);
    send_request(F_POP,      6'd0,  32'h0);
    send_request(F_REMOVE,   6'd0,  32'h0);
    send_request(F_SEARCH,   6'd0,  32'h5A5A_5A5A);
    send_request(F_PUT,      6'd63, 32'h8000_0000);
    send_request(F_POP,      6'd0,  32'h0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 12; snk_stall_pct = 78; end
        1:       begin src_idle_pct = 78; snk_stall_pct = 12; end
        default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      endcase
      repeat (PHASE_ITEMS) begin
        pick_request(f, idx, w);
        send_request(f, idx, w);
      end
    end
    req_ch.valid <= 1'b0;

    while (sb.rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.rsp_q.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.rsp_q.size()));

    if (sb.errors == 0)
      $display("indexed_list_engine_unit_tb OK");
    else
      $display("indexed_list_engine_unit_tb NOT OK");
    $finish;
  end

endmodule
